FILE: sv/alag_pkg.sv
package alag_pkg;

    typedef logic [0:0] reg_index_t;

    localparam reg_index_t REG_ENABLE     = 1'd0;
    localparam reg_index_t REG_PEAK_FLOOR = 1'd1;

    localparam logic [14:0] PEAK_FLOOR_RESET = 15'd500;

    // Peak tracker in unsigned Q16.16; 1000.0 after reset.
    localparam logic [31:0] PEAK_RESET = 32'd65536000;
    // 0.999 in Q0.32.
    localparam logic [31:0] DECAY_Q32  = 32'd4290672329;
    // 1.4 and 0.9 in Q.16.
    localparam logic [16:0] BASS_GAIN   = 17'd91750;
    localparam logic [16:0] TREBLE_GAIN = 17'd58982;
    localparam logic [15:0] ONE_Q16     = 16'hFFFF;

    // Smoothing weights, each pair sums to one in Q0.16.
    localparam logic [15:0] LEVEL_A  = 16'd52429;
    localparam logic [15:0] LEVEL_B  = 16'd13107;
    localparam logic [15:0] BASS_A   = 16'd55706;
    localparam logic [15:0] BASS_B   = 16'd9830;
    localparam logic [15:0] TREBLE_A = 16'd45875;
    localparam logic [15:0] TREBLE_B = 16'd19661;

endpackage

FILE: sv/alag_div.sv
module alag_div
    import alag_pkg::*;
#(
    parameter int DVD_W = 76
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [31:0]      divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int NW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      dvs_reg;
    logic [NW-1:0]    cnt_reg;
    logic             done_reg;

    logic [32:0] rem_sh;
    logic        ge;
    logic [31:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_next = ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
    end

    // One quotient bit per cycle, restoring long division.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            cnt_reg  <= NW'(DVD_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[DVD_W-2:0], ge};
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == NW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/alag_front.sv
module alag_front
    import alag_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int CW  = 13,
    parameter int SQW = 44,
    parameter int MW  = 29,
    parameter int EW  = 29,
    parameter int W   = 116
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         enable,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [15:0]  in_sample,
    input  logic         in_last,
    input  logic         full,
    output logic         push,
    output logic [W-1:0] push_data
);

    logic [SQW-1:0] sq_reg, sq_next;
    logic [MW-1:0]  mag_reg, mag_next;
    logic [EW-1:0]  dif_reg, dif_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [15:0]    prev_reg, prev_next;
    logic           open_reg, open_next;
    logic           ovr_reg, ovr_next;

    logic           accept;
    logic           start;
    logic [15:0]    prev_eff;
    logic [16:0]    diff;
    logic [16:0]    abs_diff;
    logic [16:0]    abs_s;
    logic [31:0]    square;

    always_comb
    begin
        in_ready = !enable || !full;
        accept   = in_valid && in_ready && enable;
        start    = !open_reg;
        prev_eff = start ? in_sample : prev_reg;
        diff     = {in_sample[15], in_sample} - {prev_eff[15], prev_eff};
        abs_diff = diff[16] ? 17'(-diff) : diff;
        abs_s    = in_sample[15] ? 17'(-{1'b1, in_sample}) : {1'b0, in_sample};
        square   = 32'($signed(in_sample) * $signed(in_sample));

        sq_next   = start ? '0 : sq_reg;
        mag_next  = start ? '0 : mag_reg;
        dif_next  = start ? '0 : dif_reg;
        cnt_next  = start ? '0 : cnt_reg;
        ovr_next  = start ? 1'b0 : ovr_reg;
        prev_next = prev_eff;
        open_next = !in_last;

        if (cnt_next < CW'(MAX_SAMPLES))
        begin
            sq_next   = sq_next + SQW'(square);
            mag_next  = mag_next + MW'(abs_s);
            dif_next  = dif_next + EW'(abs_diff);
            cnt_next  = cnt_next + 1'b1;
            prev_next = in_sample;
        end
        else
        begin
            ovr_next = 1'b1;
        end

        push      = accept && in_last;
        push_data = {ovr_next, cnt_next, dif_next, mag_next, sq_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg   <= '0;
            mag_reg  <= '0;
            dif_reg  <= '0;
            cnt_reg  <= '0;
            prev_reg <= '0;
            open_reg <= 1'b0;
            ovr_reg  <= 1'b0;
        end
        else if (accept)
        begin
            sq_reg   <= sq_next;
            mag_reg  <= mag_next;
            dif_reg  <= dif_next;
            cnt_reg  <= cnt_next;
            prev_reg <= prev_next;
            open_reg <= open_next;
            ovr_reg  <= ovr_next;
        end
    end

endmodule

FILE: sv/alag_fifo.sv
module alag_fifo
    import alag_pkg::*;
#(
    parameter int W = 116
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         full,
    output logic         empty,
    output logic [W-1:0] pop_data
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] rd_reg;
    logic [AW:0]   cnt_reg;

    assign full     = cnt_reg == (AW+1)'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_data = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

FILE: sv/alag_back.sv
module alag_back
    import alag_pkg::*;
#(
    parameter int CW    = 13,
    parameter int SQW   = 44,
    parameter int MW    = 29,
    parameter int EW    = 29,
    parameter int W     = 116,
    parameter int DVD_W = 76
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  logic [W-1:0] q_data,
    output logic         q_pop,
    input  logic [14:0]  peak_floor,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [47:0]  out_data,
    output logic         out_flag
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_SQRT, ST_PMUL, ST_PFLOOR, ST_SMOOTH, ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_MSQ, OP_MAG, OP_DIFF, OP_LV, OP_BS, OP_TR
    } op_t;

    state_t state_reg;
    op_t    op_reg;

    logic [MW-1:0]    mag_sum_reg;
    logic [EW-1:0]    dif_sum_reg;
    logic [31:0]      n_reg;
    logic             ovr_reg;

    logic             div_start_reg;
    logic [DVD_W-1:0] div_dvd_reg;
    logic [31:0]      div_dvs_reg;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;

    logic [63:0]      sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [4:0]       sq_cnt_reg;

    logic [31:0]      rms_reg;
    logic [31:0]      mean_mag_reg;
    logic [31:0]      mean_dif_reg;
    logic [31:0]      peak_reg;
    logic [15:0]      lv_reg, bs_reg, tr_reg;
    logic [15:0]      sm_lv_reg, sm_bs_reg, sm_tr_reg;
    logic [1:0]       sm_idx_reg;

    logic             out_valid_reg;
    logic [47:0]      out_data_reg;
    logic             out_flag_reg;

    logic [SQW-1:0]   sq_in;
    logic [MW-1:0]    mag_in;
    logic [EW-1:0]    dif_in;
    logic [CW-1:0]    cnt_in;
    logic [63:0]      sq_t;
    logic             sq_ge;
    logic [15:0]      quo_sat;
    logic [31:0]      floor_q;
    logic [31:0]      peak_fl;
    logic [63:0]      decay_prod;
    logic [15:0]      sm_prev, sm_x, sm_a, sm_b, sm_new;
    logic [32:0]      sm_sum;

    alag_div #(.DVD_W(DVD_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dvs_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        sq_in  = q_data[SQW-1:0];
        mag_in = q_data[SQW +: MW];
        dif_in = q_data[SQW+MW +: EW];
        cnt_in = q_data[SQW+MW+EW +: CW];

        sq_t  = sq_r_reg + sq_bit_reg;
        sq_ge = sq_v_reg >= sq_t;

        quo_sat = (div_quo[DVD_W-1:16] != '0) ? ONE_Q16 : div_quo[15:0];

        floor_q    = {1'b0, (peak_floor == '0) ? 15'd1 : peak_floor, 16'h0000};
        peak_fl    = (peak_reg < floor_q) ? floor_q : peak_reg;
        decay_prod = peak_reg * DECAY_Q32;

        case (sm_idx_reg)
            2'd0:
            begin
                sm_prev = sm_lv_reg; sm_x = lv_reg; sm_a = LEVEL_A; sm_b = LEVEL_B;
            end
            2'd1:
            begin
                sm_prev = sm_bs_reg; sm_x = bs_reg; sm_a = BASS_A; sm_b = BASS_B;
            end
            default:
            begin
                sm_prev = sm_tr_reg; sm_x = tr_reg; sm_a = TREBLE_A; sm_b = TREBLE_B;
            end
        endcase
        sm_sum = 33'(sm_prev * sm_a) + 33'(sm_x * sm_b);
        sm_new = (sm_x > sm_prev) ? sm_x : sm_sum[31:16];

        q_pop = (state_reg == ST_IDLE) && !q_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_MSQ;
            div_start_reg <= 1'b0;
            peak_reg      <= PEAK_RESET;
            sm_lv_reg     <= '0;
            sm_bs_reg     <= '0;
            sm_tr_reg     <= '0;
            sm_idx_reg    <= '0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            // In ST_EMIT the emit branch below decides the output valid.
            if (out_valid_reg && out_ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        mag_sum_reg   <= mag_in;
                        dif_sum_reg   <= dif_in;
                        n_reg         <= (cnt_in == '0) ? 32'd1 : 32'(cnt_in);
                        ovr_reg       <= q_data[W-1];
                        div_dvd_reg   <= DVD_W'({sq_in, 32'h0});
                        div_dvs_reg   <= (cnt_in == '0) ? 32'd1 : 32'(cnt_in);
                        div_start_reg <= 1'b1;
                        op_reg        <= OP_MSQ;
                        state_reg     <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        unique case (op_reg)
                            OP_MSQ:
                            begin
                                sq_v_reg   <= div_quo[63:0];
                                sq_r_reg   <= '0;
                                sq_bit_reg <= 64'h4000_0000_0000_0000;
                                sq_cnt_reg <= 5'd31;
                                state_reg  <= ST_SQRT;
                            end
                            OP_MAG:
                            begin
                                mean_mag_reg  <= div_quo[31:0];
                                div_dvd_reg   <= DVD_W'({dif_sum_reg, 16'h0000});
                                div_start_reg <= 1'b1;
                                op_reg        <= OP_DIFF;
                            end
                            OP_DIFF:
                            begin
                                mean_dif_reg <= div_quo[31:0];
                                state_reg    <= ST_PMUL;
                            end
                            OP_LV:
                            begin
                                lv_reg        <= quo_sat;
                                div_dvd_reg   <= DVD_W'(mean_mag_reg * BASS_GAIN);
                                div_start_reg <= 1'b1;
                                op_reg        <= OP_BS;
                            end
                            OP_BS:
                            begin
                                bs_reg        <= quo_sat;
                                div_dvd_reg   <= DVD_W'(mean_dif_reg * TREBLE_GAIN);
                                div_start_reg <= 1'b1;
                                op_reg        <= OP_TR;
                            end
                            default:
                            begin
                                tr_reg     <= quo_sat;
                                sm_idx_reg <= '0;
                                state_reg  <= ST_SMOOTH;
                            end
                        endcase
                    end
                end

                // Integer square root, two radicand bits per step.
                ST_SQRT:
                begin
                    if (sq_ge)
                    begin
                        sq_v_reg <= sq_v_reg - sq_t;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg - 1'b1;
                    if (sq_cnt_reg == '0)
                    begin
                        rms_reg       <= sq_ge ? 32'((sq_r_reg >> 1) + sq_bit_reg)
                                               : 32'(sq_r_reg >> 1);
                        div_dvd_reg   <= DVD_W'({mag_sum_reg, 16'h0000});
                        div_dvs_reg   <= n_reg;
                        div_start_reg <= 1'b1;
                        op_reg        <= OP_MAG;
                        state_reg     <= ST_DIV;
                    end
                end

                ST_PMUL:
                begin
                    peak_reg  <= (rms_reg > peak_reg) ? rms_reg : decay_prod[63:32];
                    state_reg <= ST_PFLOOR;
                end

                ST_PFLOOR:
                begin
                    peak_reg      <= peak_fl;
                    div_dvd_reg   <= DVD_W'({rms_reg, 16'h0000});
                    div_dvs_reg   <= peak_fl;
                    div_start_reg <= 1'b1;
                    op_reg        <= OP_LV;
                    state_reg     <= ST_DIV;
                end

                ST_SMOOTH:
                begin
                    case (sm_idx_reg)
                        2'd0:    sm_lv_reg <= sm_new;
                        2'd1:    sm_bs_reg <= sm_new;
                        default: sm_tr_reg <= sm_new;
                    endcase
                    sm_idx_reg <= sm_idx_reg + 1'b1;
                    if (sm_idx_reg == 2'd2)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end

                ST_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {sm_tr_reg, sm_bs_reg, sm_lv_reg};
                        out_flag_reg  <= ovr_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_flag  = out_flag_reg;

endmodule

FILE: sv/audio_level_analyzer_agc.sv
// RMS level meter with AGC. Samples enter at one beat per cycle; the front end
// keeps the sums of squares, magnitudes and absolute differences of the open
// buffer, and a beat with tlast hands the buffer's totals to a two-entry queue.
// The back end then works one buffer at a time: six long divisions on one
// shared bit-serial divider, a 32-step square root, then the peak update and
// smoothing. The input stalls only when two closed buffers wait in the queue.
// While enable is low every beat is taken and ignored. Outputs are unsigned
// Q0.16; tuser flags dropped samples.
module audio_level_analyzer_agc
    import alag_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // level, bass, treble
    output logic        m_tuser,   // overrun
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  reg_index_t  cfg_index,
    input  logic [14:0] cfg_data
);

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SQW   = 31 + CW;
    localparam int MW    = 16 + CW;
    localparam int EW    = 16 + CW;
    localparam int W     = SQW + MW + EW + CW + 1;
    localparam int DVD_W = SQW + 32;

    logic         enable_reg;
    logic [14:0]  peak_floor_reg;
    logic         push, pop, full, empty;
    logic [W-1:0] push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            peak_floor_reg <= PEAK_FLOOR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ENABLE:     enable_reg     <= cfg_data[0];
                REG_PEAK_FLOOR: peak_floor_reg <= cfg_data;
                default:        enable_reg     <= enable_reg;
            endcase
        end
    end

    alag_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW (CW), .SQW (SQW), .MW (MW), .EW (EW), .W (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (enable_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata),
        .in_last   (s_tlast),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    alag_fifo #(.W (W)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .pop_data  (pop_data)
    );

    alag_back #(
        .CW (CW), .SQW (SQW), .MW (MW), .EW (EW), .W (W), .DVD_W (DVD_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (empty),
        .q_data     (pop_data),
        .q_pop      (pop),
        .peak_floor (peak_floor_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_flag   (m_tuser)
    );

endmodule

FILE: sv/alag_checker.sv
module alag_checker
    import alag_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input reg_index_t  cfg_index,
    input logic [14:0] cfg_data
);

    // A result held back by the sink stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // The offered result does not change while it waits.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Register writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

    // Offered beats and register writes carry known values.
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid || cfg_valid) |-> !$isunknown({s_tdata, s_tlast, cfg_index, cfg_data}))
        else $error("unknown value on an offered beat");

    // The back end needs many cycles, so a closing beat never yields a
    // result on the very next cycle.
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready && s_tlast))
        else $error("result appeared too soon after buffer close");

endmodule

bind audio_level_analyzer_agc alag_checker u_alag_checker (.*);

FILE: tb/tb_audio_level_analyzer_agc.sv
module tb_audio_level_analyzer_agc;
    import alag_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] pcm;
        logic               close;
    } pcm_beat_t;

    typedef struct packed {
        logic [15:0] level;
        logic [15:0] bass;
        logic [15:0] treble;
        logic        overrun;
    } meter_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    reg_index_t  cfg_index;
    logic [14:0] cfg_data;

    audio_level_analyzer_agc dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Stimulus and expected meter readings.
    pcm_beat_t  pcm_pending[$];
    meter_out_t meter_expected[$];
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_off_cycles = 0;
    logic       in_taken;

    // Shadow of the block's registers and state.
    logic        meter_enable;
    logic [14:0] meter_floor;
    logic [63:0] sum_sq;
    logic [63:0] sum_mag;
    logic [63:0] sum_diff;
    logic [31:0] n_samples;
    logic signed [31:0] prev_pcm;
    logic        in_buffer;
    logic        dropped;
    logic [63:0] peak_q16;
    logic [15:0] lvl_smooth;
    logic [15:0] bass_smooth;
    logic [15:0] treb_smooth;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] smooth_step(logic [15:0] prev, logic [63:0] x,
                                                logic [63:0] a, logic [63:0] b);
        logic [63:0] mix;
        if (x > prev)
            return x[15:0];
        mix = (prev * a + x * b) >> 16;
        return mix[15:0];
    endfunction

    function automatic logic [63:0] clamp_one(logic [63:0] v);
        return (v > ONE_Q16) ? 64'(ONE_Q16) : v;
    endfunction

    task automatic reset_meter_model();
        meter_enable = 1'b0;
        meter_floor  = PEAK_FLOOR_RESET;
        sum_sq = 0;
        sum_mag = 0;
        sum_diff = 0;
        n_samples = 0;
        prev_pcm = 0;
        in_buffer = 1'b0;
        dropped = 1'b0;
        peak_q16 = PEAK_RESET;
        lvl_smooth = 0;
        bass_smooth = 0;
        treb_smooth = 0;
    endtask

    // Advances the shadow state by one accepted sample and queues the reading
    // that a closing sample produces.
    task automatic meter_accept(logic signed [15:0] pcm, logic close);
        logic signed [31:0] s;
        logic signed [31:0] d;
        logic [63:0] n;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] rms;
        logic [63:0] mmag;
        logic [63:0] mdiff;
        logic [63:0] flo;
        meter_out_t  res;
        s = pcm;
        if (!meter_enable)
            return;
        if (!in_buffer)
        begin
            sum_sq = 0;
            sum_mag = 0;
            sum_diff = 0;
            n_samples = 0;
            dropped = 1'b0;
            prev_pcm = s;
            in_buffer = 1'b1;
        end
        if (n_samples < 4096)
        begin
            d = s - prev_pcm;
            sum_sq += 64'(s * s);
            sum_mag += 64'((s < 0) ? -s : s);
            sum_diff += 64'((d < 0) ? -d : d);
            n_samples++;
            prev_pcm = s;
        end
        else
            dropped = 1'b1;
        if (!close)
            return;
        n = (n_samples != 0) ? 64'(n_samples) : 64'd1;
        q = sum_sq / n;
        r = sum_sq % n;
        rms = int_sqrt((q << 32) + ((r << 32) / n));
        mmag = (sum_mag << 16) / n;
        mdiff = (sum_diff << 16) / n;
        flo = 64'((meter_floor != 0) ? meter_floor : 15'd1) << 16;
        if (rms > peak_q16)
            peak_q16 = rms;
        else
            peak_q16 = (peak_q16 * 64'(DECAY_Q32)) >> 32;
        if (peak_q16 < flo)
            peak_q16 = flo;
        lvl_smooth = smooth_step(lvl_smooth, clamp_one((rms << 16) / peak_q16),
                                 LEVEL_A, LEVEL_B);
        bass_smooth = smooth_step(bass_smooth,
                                  clamp_one((mmag * BASS_GAIN) / peak_q16), BASS_A, BASS_B);
        treb_smooth = smooth_step(treb_smooth,
                                  clamp_one((mdiff * TREBLE_GAIN) / peak_q16),
                                  TREBLE_A, TREBLE_B);
        res.level = lvl_smooth;
        res.bass = bass_smooth;
        res.treble = treb_smooth;
        res.overrun = dropped;
        meter_expected.push_back(res);
        in_buffer = 1'b0;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Sender: a beat stays on the bus until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (pcm_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pcm_pending[0].pcm;
                s_tlast  <= pcm_pending[0].close;
                void'(pcm_pending.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver stalls, including a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        in_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            meter_accept(s_tdata, s_tlast);
    end

    always @(posedge clk)
    begin
        meter_out_t want;
        if (m_tvalid && m_tready)
        begin
            if (meter_expected.size() == 0)
                report_mismatch("unexpected beat, level", m_tdata[15:0], 0);
            else
            begin
                want = meter_expected.pop_front();
                if (m_tdata[15:0] !== want.level)
                    report_mismatch("level", m_tdata[15:0], want.level);
                if (m_tdata[31:16] !== want.bass)
                    report_mismatch("bass", m_tdata[31:16], want.bass);
                if (m_tdata[47:32] !== want.treble)
                    report_mismatch("treble", m_tdata[47:32], want.treble);
                if (m_tuser !== want.overrun)
                    report_mismatch("overrun", m_tuser, want.overrun);
            end
        end
    end

    task automatic write_reg(reg_index_t idx, logic [14:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_ENABLE)
            meter_enable = value[0];
        else
            meter_floor = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until all beats are sent and all expected readings are received, then allows extra time.
    task automatic drain();
        wait (pcm_pending.size() == 0 && !s_tvalid && meter_expected.size() == 0);
        repeat (1000) @(posedge clk);
    endtask

    task automatic push_pcm(int value, bit close);
        pcm_beat_t b;
        b.pcm = 16'(value);
        b.close = close;
        pcm_pending.push_back(b);
    endtask

    function automatic int random_pcm();
        case ($urandom_range(0, 5))
            0: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            1: return int'($urandom_range(0, 128)) - 64;
            2: return ($urandom_range(0, 1) != 0) ? 0 : -1;
            default: return int'(signed'(16'($urandom)));
        endcase
    endfunction

    task automatic random_phase(int count);
        int len;
        while (count > 0)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 10);
            for (int k = 0; k < len; k++)
                push_pcm(random_pcm(), k == len - 1);
            count -= len;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ENABLE;
        cfg_data = '0;
        in_taken = 1'b0;
        reset_meter_model();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, a single-sample buffer, silence after loud
        // buffers to exercise decay and smoothing.
        write_reg(REG_ENABLE, 15'd1);
        push_pcm(32767, 0);
        push_pcm(-32768, 0);
        push_pcm(32767, 0);
        push_pcm(-32768, 1);
        push_pcm(0, 1);
        push_pcm(-32768, 1);
        push_pcm(1, 0);
        push_pcm(-1, 0);
        push_pcm(0, 1);
        push_pcm(0, 0);
        push_pcm(0, 1);
        drain();
        write_reg(REG_PEAK_FLOOR, 15'd32767);
        push_pcm(100, 0);
        push_pcm(200, 1);
        drain();
        write_reg(REG_PEAK_FLOOR, 15'd0);
        push_pcm(5, 1);
        drain();
        write_reg(REG_PEAK_FLOOR, 15'd1);
        push_pcm(3, 1);
        drain();

        // Disabled: beats are swallowed, an open buffer survives.
        write_reg(REG_ENABLE, 15'd0);
        push_pcm(7, 0);
        push_pcm(8, 1);
        drain();
        write_reg(REG_ENABLE, 15'd1);
        push_pcm(10, 0);
        push_pcm(20, 0);
        drain();
        write_reg(REG_ENABLE, 15'd0);
        push_pcm(999, 1);
        drain();
        write_reg(REG_ENABLE, 15'd1);
        push_pcm(30, 1);
        drain();

        write_reg(REG_PEAK_FLOOR, 15'd500);

        send_idle_pct = 10;
        recv_stall_pct = 75;
        random_phase(580);
        drain();
        write_reg(REG_PEAK_FLOOR, 15'($urandom_range(1, 32767)));

        send_idle_pct = 75;
        recv_stall_pct = 10;
        random_phase(580);
        drain();
        write_reg(REG_PEAK_FLOOR, 15'd32767);

        // Long receiver hold-off while the sender keeps offering short buffers.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        hold_off_cycles = 4000;
        for (int k = 0; k < 40; k++)
            push_pcm(random_pcm(), (k % 2) == 1);
        random_phase(540);
        drain();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("status: fail");
        $finish;
    end

endmodule
